>>> rtl/sps_pkg.sv
`default_nettype none

package sps_pkg;

    localparam int DATA_W     = 32;
    localparam int MAX_STRIDE = 4096;
    localparam int COL_W      = $clog2(MAX_STRIDE);
    localparam int STRIDE_W   = 13;
    localparam int PRIME_W    = 17;
    localparam int ROW_W      = 17;
    localparam int BLK_W      = 16;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = 3;

    // register indexes, byte address = 4 * index
    localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODULUS     = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRIME       = 3'd2;
    localparam logic [IDX_W-1:0] REG_STRIDE      = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLOCK_COUNT = 3'd4;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [DATA_W-1:0]   modulus;
        logic [PRIME_W-1:0]  prime;
        logic [STRIDE_W-1:0] stride;
        logic [BLK_W-1:0]    block_count;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/sps_ram.sv
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sps_mod_unit.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module sps_mod_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sps_pkg::DATA_W-1:0] dividend,
    input  wire logic [sps_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic      [sps_pkg::DATA_W-1:0] rem
);

    localparam int CNT_W = $clog2(sps_pkg::DATA_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [sps_pkg::DATA_W-1:0]    rem_reg;
    logic [sps_pkg::DATA_W-1:0]    dvd_reg;
    logic [sps_pkg::DATA_W-1:0]    dsr_reg;
    logic [sps_pkg::DATA_W:0]      trial;
    logic [sps_pkg::DATA_W-1:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[sps_pkg::DATA_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = sps_pkg::DATA_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[sps_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(sps_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[sps_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/sps_cfg.sv
`default_nettype none

module sps_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output sps_pkg::cfg_t                     cfg
);

    sps_pkg::cfg_t                 cfg_reg;
    logic [sps_pkg::IDX_W-1:0]     idx;
    logic                          wr;

    assign idx    = paddr[sps_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= sps_pkg::MODE_FWD;
            cfg_reg.modulus     <= '0;
            cfg_reg.prime       <= sps_pkg::PRIME_W'(2);
            cfg_reg.stride      <= sps_pkg::STRIDE_W'(1);
            cfg_reg.block_count <= sps_pkg::BLK_W'(1);
        end
        else if (wr)
        begin
            case (idx)
                sps_pkg::REG_MODE:        cfg_reg.mode        <= pwdata[0];
                sps_pkg::REG_MODULUS:     cfg_reg.modulus     <= pwdata;
                sps_pkg::REG_PRIME:       cfg_reg.prime       <= pwdata[sps_pkg::PRIME_W-1:0];
                sps_pkg::REG_STRIDE:      cfg_reg.stride      <= pwdata[sps_pkg::STRIDE_W-1:0];
                sps_pkg::REG_BLOCK_COUNT: cfg_reg.block_count <= pwdata[sps_pkg::BLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sps_pkg::REG_MODE:        prdata = 32'(cfg_reg.mode);
            sps_pkg::REG_MODULUS:     prdata = cfg_reg.modulus;
            sps_pkg::REG_PRIME:       prdata = 32'(cfg_reg.prime);
            sps_pkg::REG_STRIDE:      prdata = 32'(cfg_reg.stride);
            sps_pkg::REG_BLOCK_COUNT: prdata = 32'(cfg_reg.block_count);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/strided_prefix_sum_difference.sv
// With canonical operands a coefficient passes S0, S1 and the result register; one item
// per cycle while the output is not stalled and no reduction runs, set by the single
// read-modify-write pass over the column memory per item. A coefficient at or above a
// nonzero modulus, or a stored column value left above a newly written modulus, holds
// S1 for a reduction in the shared bit-serial remainder unit. Reset (rst_n, async,
// active low) clears counters, valids, config and S1 registers; memory is not cleared.
`default_nettype none

module strided_prefix_sum_difference (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,   // [31:0] coef
    input  wire logic [0:0]                  s_axis_tuser,   // [0] restart
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [31:0]                 m_axis_tdata,   // [31:0] result
    output logic      [0:0]                  m_axis_tuser,   // [0] block_end
    output logic                             m_axis_tlast,   // tensor_end
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int DW = sps_pkg::DATA_W;
    localparam int CW = sps_pkg::COL_W;
    localparam int SW = sps_pkg::STRIDE_W;
    localparam int RW = sps_pkg::ROW_W;
    localparam int BW = sps_pkg::BLK_W;

    typedef enum logic [1:0] {
        S1_CHECK,
        S1_WAIT_X,
        S1_WAIT_S
    } s1_state_t;

    sps_pkg::cfg_t cfg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    sps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Position counters and effective limits
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_pos_reg;
    logic [RW-1:0]  row_pos_reg;
    logic [BW-1:0]  blk_pos_reg;
    logic [SW-1:0]  cols;
    logic [RW-1:0]  rows;
    logic [BW-1:0]  blocks;
    logic [CW-1:0]  col_eff;
    logic [RW-1:0]  row_eff;
    logic [BW-1:0]  blk_eff;
    logic           last_col;
    logic           last_row;
    logic           last_blk;
    logic           restart;

    always_comb
    begin
        // clamp stride to [1, MAX_STRIDE], prime below 2 acts as 2, zero blocks as 1
        if (cfg.stride == '0)
        begin
            cols = SW'(1);
        end
        else if (cfg.stride > SW'(sps_pkg::MAX_STRIDE))
        begin
            cols = SW'(sps_pkg::MAX_STRIDE);
        end
        else
        begin
            cols = cfg.stride;
        end

        if (cfg.prime < sps_pkg::PRIME_W'(2))
        begin
            rows = RW'(1);
        end
        else
        begin
            rows = RW'(cfg.prime - sps_pkg::PRIME_W'(1));
        end

        blocks = (cfg.block_count == '0) ? BW'(1) : cfg.block_count;

        restart = s_axis_tuser[0];
        col_eff = restart ? '0 : col_pos_reg;
        row_eff = restart ? '0 : row_pos_reg;
        blk_eff = restart ? '0 : blk_pos_reg;

        // a position at or beyond a shrunken limit counts as the last one
        last_col = (SW'({1'b0, col_eff}) + SW'(1)) >= cols;
        last_row = ({1'b0, row_eff} + (RW+1)'(1)) >= {1'b0, rows};
        last_blk = ({1'b0, blk_eff} + (BW+1)'(1)) >= {1'b0, blocks};
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   S0: accepted item, column read issued on its move to S1
    //   S1: operand check, reduction, modular add/subtract, memory write
    //   out: result register
    // ------------------------------------------------------------------
    logic                s0_valid_reg;
    logic [DW-1:0]       s0_coef_reg;
    logic [CW-1:0]       s0_idx_reg;
    logic                s0_row0_reg;
    logic                s0_bend_reg;
    logic                s0_tend_reg;

    logic                s1_valid_reg;
    s1_state_t           s1_state_reg;
    logic [DW-1:0]       s1_x_reg;
    logic [DW-1:0]       s1_s_reg;
    logic                s1_live_reg;
    logic [CW-1:0]       s1_idx_reg;
    logic                s1_row0_reg;
    logic                s1_bend_reg;
    logic                s1_tend_reg;

    logic                out_valid_reg;
    logic [DW-1:0]       out_result_reg;
    logic                out_bend_reg;
    logic                out_tend_reg;

    logic                fwd_valid_reg;
    logic [CW-1:0]       fwd_idx_reg;
    logic [DW-1:0]       fwd_data_reg;

    logic [DW-1:0]       ram_rdata;
    logic [DW-1:0]       s_cur;
    logic                mod_on;
    logic                need_x;
    logic                need_s;
    logic                s1_done;
    logic                out_free;
    logic                s1_fire;
    logic                s1_take;
    logic                s0_fire;
    logic                in_fire;
    logic                mod_start;
    logic                mod_done;
    logic [DW-1:0]       mod_rem;
    logic [DW:0]         sum;
    logic [DW-1:0]       y;
    logic [DW-1:0]       store_val;

    // Take the stored operand from the last write when it hit the same column;
    // the forwarding register always holds the newest write, so a hit is current.
    assign s_cur = s1_live_reg
                 ? ((fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_data_reg : ram_rdata)
                 : s1_s_reg;

    assign mod_on  = (cfg.modulus != '0);
    assign need_x  = mod_on && (s1_x_reg >= cfg.modulus);
    assign need_s  = !s1_row0_reg && mod_on && (s_cur >= cfg.modulus);
    assign s1_done = s1_valid_reg && (s1_state_reg == S1_CHECK) && !need_x && !need_s;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_done && out_free;
    assign s1_take       = !s1_valid_reg || s1_fire;
    assign s0_fire       = s0_valid_reg && s1_take;
    assign s_axis_tready = !s0_valid_reg || s1_take;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign mod_start = s1_valid_reg && (s1_state_reg == S1_CHECK) && (need_x || need_s);

    // ------------------------------------------------------------------
    // Modular arithmetic on canonical operands
    // ------------------------------------------------------------------
    always_comb
    begin
        sum = {1'b0, s1_x_reg} + {1'b0, s_cur};
        if (s1_row0_reg)
        begin
            y = s1_x_reg;
        end
        else if (cfg.mode == sps_pkg::MODE_FWD)
        begin
            if (mod_on && (sum >= {1'b0, cfg.modulus}))
            begin
                y = DW'(sum - {1'b0, cfg.modulus});
            end
            else
            begin
                y = sum[DW-1:0];
            end
        end
        else
        begin
            // wrap of x - s + modulus stays below modulus
            if (mod_on && (s1_x_reg < s_cur))
            begin
                y = s1_x_reg - s_cur + cfg.modulus;
            end
            else
            begin
                y = s1_x_reg - s_cur;
            end
        end

        // forward mode keeps the running sum, inverse and first row keep the input
        if (!s1_row0_reg && (cfg.mode == sps_pkg::MODE_FWD))
        begin
            store_val = y;
        end
        else
        begin
            store_val = s1_x_reg;
        end
    end

    // ------------------------------------------------------------------
    // Column memory and shared remainder unit
    // ------------------------------------------------------------------
    sps_ram #(
        .WIDTH (DW),
        .DEPTH (sps_pkg::MAX_STRIDE)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_idx_reg),
        .wdata (store_val),
        .re    (s0_fire),
        .raddr (s0_idx_reg),
        .rdata (ram_rdata)
    );

    sps_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (need_x ? s1_x_reg : s_cur),
        .divisor  (cfg.modulus),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // ------------------------------------------------------------------
    // Counters and S0
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            blk_pos_reg  <= '0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                // advance column, then row, then block
                if (!last_col)
                begin
                    col_pos_reg <= col_eff + CW'(1);
                    row_pos_reg <= row_eff;
                    blk_pos_reg <= blk_eff;
                end
                else
                begin
                    col_pos_reg <= '0;
                    if (!last_row)
                    begin
                        row_pos_reg <= row_eff + RW'(1);
                        blk_pos_reg <= blk_eff;
                    end
                    else
                    begin
                        row_pos_reg <= '0;
                        blk_pos_reg <= last_blk ? '0 : blk_eff + BW'(1);
                    end
                end
            end
            if (s_axis_tready)
            begin
                s0_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_coef_reg <= s_axis_tdata;
            s0_idx_reg  <= col_eff;
            s0_row0_reg <= (row_eff == '0);
            s0_bend_reg <= last_col && last_row;
            s0_tend_reg <= last_col && last_row && last_blk;
        end
    end

    // ------------------------------------------------------------------
    // S1: check operands, reduce the one that is out of range, finish
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_state_reg <= S1_CHECK;
            s1_live_reg  <= 1'b0;
            s1_x_reg     <= '0;
            s1_s_reg     <= '0;
            s1_idx_reg   <= '0;
            s1_row0_reg  <= 1'b0;
            s1_bend_reg  <= 1'b0;
            s1_tend_reg  <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= s0_valid_reg;
            s1_state_reg <= S1_CHECK;
            s1_live_reg  <= 1'b1;
            s1_x_reg     <= s0_coef_reg;
            s1_idx_reg   <= s0_idx_reg;
            s1_row0_reg  <= s0_row0_reg;
            s1_bend_reg  <= s0_bend_reg;
            s1_tend_reg  <= s0_tend_reg;
        end
        else if (s1_valid_reg)
        begin
            case (s1_state_reg)
                S1_CHECK:
                begin
                    if (need_x || need_s)
                    begin
                        // hold the stored operand; memory read data moves on
                        s1_s_reg     <= s_cur;
                        s1_live_reg  <= 1'b0;
                        s1_state_reg <= need_x ? S1_WAIT_X : S1_WAIT_S;
                    end
                end
                S1_WAIT_X:
                begin
                    if (mod_done)
                    begin
                        s1_x_reg     <= mod_rem;
                        s1_state_reg <= S1_CHECK;
                    end
                end
                S1_WAIT_S:
                begin
                    if (mod_done)
                    begin
                        s1_s_reg     <= mod_rem;
                        s1_state_reg <= S1_CHECK;
                    end
                end
                default:
                begin
                    s1_state_reg <= S1_CHECK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Forwarding register and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            fwd_idx_reg    <= s1_idx_reg;
            fwd_data_reg   <= store_val;
            out_result_reg <= y;
            out_bend_reg   <= s1_bend_reg;
            out_tend_reg   <= s1_tend_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_result_reg;
    assign m_axis_tuser[0] = out_bend_reg;
    assign m_axis_tlast    = out_tend_reg;

endmodule

`default_nettype wire
